@@ hdl/ris_pkg.sv @@
// ris_pkg: shared types, widths and the control store for the radical inverse sequencer
// holds the micro-op and branch encodings, the control word layout and the program
// no dependencies
package ris_pkg;

  localparam int IDX_W      = 32;                    // sequence index, wraps at 2^32
  localparam int FRAC_W     = 32;                    // fraction bits of the point
  localparam int DIV_W      = 32;                    // dividend low word / quotient
  localparam int RADIX_W    = 9;
  localparam int DIGIT_W    = RADIX_W;
  localparam int MAX_DIGITS = 32;                    // base two needs one digit per bit
  localparam int DPTR_W     = $clog2(MAX_DIGITS);
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int ACC_W      = 41;                    // radix^digits stays below 2^41
  localparam int DCYC_W     = $clog2(DIV_W);
  localparam int UPC_W      = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_START      = 4'd1,
    OP_CONV_LOAD  = 4'd2,
    OP_DIV_STEP   = 4'd3,
    OP_CONV_DIGIT = 4'd4,
    OP_INC        = 4'd5,
    OP_ACC_INIT   = 4'd6,
    OP_ACC_STEP   = 4'd7,
    OP_DIV_LOAD   = 4'd8,
    OP_FINISH     = 4'd9
  } op_e;

  typedef enum logic [3:0] {
    COND_ALWAYS       = 4'd0,
    COND_NO_START     = 4'd1,
    COND_DIGITS_OK    = 4'd2,
    COND_IDX_ZERO     = 4'd3,
    COND_DIV_MORE     = 4'd4,
    COND_QUOT_NONZERO = 4'd5,
    COND_CARRY        = 4'd6,
    COND_ACC_MORE     = 4'd7,
    COND_OUT_FREE     = 4'd8
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic digits_ok;
    logic idx_zero;
    logic div_more;
    logic quot_nonzero;
    logic carry;
    logic acc_more;
  } dp_status_t;

  // program addresses
  localparam logic [UPC_W-1:0] UA_IDLE       = 4'd0;
  localparam logic [UPC_W-1:0] UA_CHECK      = 4'd1;
  localparam logic [UPC_W-1:0] UA_CONV_LOAD  = 4'd2;
  localparam logic [UPC_W-1:0] UA_CONV_DIV   = 4'd3;
  localparam logic [UPC_W-1:0] UA_CONV_DIGIT = 4'd4;
  localparam logic [UPC_W-1:0] UA_CONV_DONE  = 4'd5;
  localparam logic [UPC_W-1:0] UA_INC        = 4'd6;
  localparam logic [UPC_W-1:0] UA_ACC_INIT   = 4'd7;
  localparam logic [UPC_W-1:0] UA_ACC_STEP   = 4'd8;
  localparam logic [UPC_W-1:0] UA_DIV_LOAD   = 4'd9;
  localparam logic [UPC_W-1:0] UA_DIV_RUN    = 4'd10;
  localparam logic [UPC_W-1:0] UA_FINISH     = 4'd11;
  localparam logic [UPC_W-1:0] UA_WAIT       = 4'd12;

  // control store: branch to target when cond holds, else fall through
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      UA_IDLE:       w = '{OP_START,      COND_NO_START,     UA_IDLE};
      UA_CHECK:      w = '{OP_NONE,       COND_DIGITS_OK,    UA_INC};
      UA_CONV_LOAD:  w = '{OP_CONV_LOAD,  COND_IDX_ZERO,     UA_CONV_DONE};
      UA_CONV_DIV:   w = '{OP_DIV_STEP,   COND_DIV_MORE,     UA_CONV_DIV};
      UA_CONV_DIGIT: w = '{OP_CONV_DIGIT, COND_QUOT_NONZERO, UA_CONV_DIV};
      UA_CONV_DONE:  w = '{OP_NONE,       COND_ALWAYS,       UA_ACC_INIT};
      UA_INC:        w = '{OP_INC,        COND_CARRY,        UA_INC};
      UA_ACC_INIT:   w = '{OP_ACC_INIT,   COND_ALWAYS,       UA_ACC_STEP};
      UA_ACC_STEP:   w = '{OP_ACC_STEP,   COND_ACC_MORE,     UA_ACC_STEP};
      UA_DIV_LOAD:   w = '{OP_DIV_LOAD,   COND_ALWAYS,       UA_DIV_RUN};
      UA_DIV_RUN:    w = '{OP_DIV_STEP,   COND_DIV_MORE,     UA_DIV_RUN};
      UA_FINISH:     w = '{OP_FINISH,     COND_OUT_FREE,     UA_IDLE};
      UA_WAIT:       w = '{OP_NONE,       COND_ALWAYS,       UA_FINISH};
      default:       w = '{OP_NONE,       COND_ALWAYS,       UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/ris_divider.sv @@
// ris_divider: bit-serial restoring divider, one quotient bit per cycle while step_i is high
// shared by digit extraction and the final fraction scaling
// depends on ris_pkg
module ris_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [ris_pkg::ACC_W-1:0]  rem_init_i,
  input  logic [ris_pkg::DIV_W-1:0]  num_i,
  input  logic [ris_pkg::ACC_W-1:0]  divisor_i,
  output logic [ris_pkg::DIV_W-1:0]  quot_o,
  output logic [ris_pkg::ACC_W-1:0]  rem_o,
  output logic                       more_o
);
  import ris_pkg::*;

  logic [ACC_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quot_q, quot_d;
  logic [ACC_W-1:0]  div_q, div_d;
  logic [DCYC_W-1:0] cnt_q, cnt_d;
  logic [ACC_W:0]    trial;
  logic [ACC_W:0]    diff;
  logic              fits;

  always_comb begin
    trial  = {rem_q, quot_q[DIV_W-1]};
    diff   = trial - {1'b0, div_q};
    // remainder stays below divisor, so the sign bit tells fit or not
    fits   = ~diff[ACC_W];
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      rem_d  = rem_init_i;
      quot_d = num_i;
      div_d  = divisor_i;
      cnt_d  = '0;
    end else if (step_i) begin
      rem_d  = fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
      quot_d = {quot_q[DIV_W-2:0], fits};
      cnt_d  = DCYC_W'(cnt_q + DCYC_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign more_o = (cnt_q != DCYC_W'(DIV_W - 1));

endmodule

@@ hdl/ris_datapath.sv @@
// ris_datapath: index, radix, digit store, mirror accumulators and the shared divider
// executes one micro-op per cycle from the sequencer
// depends on ris_pkg and ris_divider
module ris_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ris_pkg::op_e                 op_i,
  input  logic                         start_i,
  input  logic                         cfg_we_i,
  input  logic [ris_pkg::RADIX_W-1:0]  cfg_radix_i,
  output ris_pkg::dp_status_t          status_o,
  output logic [ris_pkg::FRAC_W-1:0]   point_o,
  output logic [ris_pkg::IDX_W-1:0]    index_o
);
  import ris_pkg::*;

  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               digits_ok_q, digits_ok_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [DCNT_W-1:0]  n_q, n_d;
  logic [DCNT_W-1:0]  ptr_q, ptr_d;
  logic [DIGIT_W-1:0] digit_q [MAX_DIGITS];
  logic [ACC_W-1:0]   m_q, m_d;
  logic [ACC_W-1:0]   p_q, p_d;

  logic [RADIX_W-1:0]       base;
  logic [RADIX_W-1:0]       base_m1;
  logic [DIGIT_W-1:0]       dig_rd;
  logic                     at_top;
  logic                     digit_max;
  logic                     dig_we;
  logic [DPTR_W-1:0]        dig_wa;
  logic [DIGIT_W-1:0]       dig_wd;
  logic [ACC_W+RADIX_W-1:0] m_prod;
  logic [ACC_W+RADIX_W-1:0] p_prod;

  logic              dv_load;
  logic              dv_step;
  logic [ACC_W-1:0]  dv_rem_init;
  logic [DIV_W-1:0]  dv_num;
  logic [ACC_W-1:0]  dv_divisor;
  logic [DIV_W-1:0]  dv_quot;
  logic [ACC_W-1:0]  dv_rem;
  logic              dv_more;

  // radix zero and one act as two
  assign base      = (radix_q < RADIX_MIN) ? RADIX_MIN : radix_q;
  assign base_m1   = RADIX_W'(base - RADIX_W'(1));
  assign dig_rd    = digit_q[ptr_q[DPTR_W-1:0]];
  assign at_top    = (ptr_q == n_q);
  assign digit_max = (dig_rd == base_m1);

  always_comb begin
    radix_d     = radix_q;
    digits_ok_d = digits_ok_q;
    idx_d       = idx_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    m_d         = m_q;
    p_d         = p_q;
    dig_we      = 1'b0;
    dig_wa      = ptr_q[DPTR_W-1:0];
    dig_wd      = '0;
    dv_load     = 1'b0;
    dv_step     = 1'b0;
    dv_rem_init = '0;
    dv_num      = idx_q;
    dv_divisor  = ACC_W'(base);
    m_prod      = m_q * base;
    p_prod      = p_q * base;
    case (op_i)
      OP_START: begin
        if (start_i) begin
          idx_d = IDX_W'(idx_q + IDX_W'(1));
          ptr_d = '0;
          // wrap to zero: redo the digits from scratch
          if (&idx_q) begin
            digits_ok_d = 1'b0;
          end
        end
      end
      OP_CONV_LOAD: begin
        n_d         = '0;
        digits_ok_d = 1'b1;
        dv_load     = 1'b1;
      end
      OP_DIV_STEP: begin
        dv_step = 1'b1;
      end
      OP_CONV_DIGIT: begin
        dig_we  = 1'b1;
        dig_wa  = n_q[DPTR_W-1:0];
        dig_wd  = dv_rem[DIGIT_W-1:0];
        n_d     = DCNT_W'(n_q + DCNT_W'(1));
        dv_load = 1'b1;
        dv_num  = dv_quot;
      end
      OP_INC: begin
        // ripple one digit per cycle
        dig_we = 1'b1;
        if (at_top) begin
          dig_wd = DIGIT_W'(1);
          n_d    = DCNT_W'(n_q + DCNT_W'(1));
        end else if (digit_max) begin
          dig_wd = '0;
          ptr_d  = DCNT_W'(ptr_q + DCNT_W'(1));
        end else begin
          dig_wd = DIGIT_W'(dig_rd + DIGIT_W'(1));
        end
      end
      OP_ACC_INIT: begin
        ptr_d = '0;
        m_d   = '0;
        p_d   = ACC_W'(1);
      end
      OP_ACC_STEP: begin
        // least significant digit becomes the leading mirrored digit
        if (ptr_q < n_q) begin
          m_d   = m_prod[ACC_W-1:0] + ACC_W'(dig_rd);
          p_d   = p_prod[ACC_W-1:0];
          ptr_d = DCNT_W'(ptr_q + DCNT_W'(1));
        end
      end
      OP_DIV_LOAD: begin
        dv_load     = 1'b1;
        dv_rem_init = m_q;
        dv_num      = '0;
        dv_divisor  = p_q;
      end
      default: begin
      end
    endcase
    if (cfg_we_i) begin
      radix_d     = cfg_radix_i;
      digits_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RESET;
      digits_ok_q <= 1'b1;
      idx_q       <= '0;
      n_q         <= '0;
      ptr_q       <= '0;
    end else begin
      radix_q     <= radix_d;
      digits_ok_q <= digits_ok_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      ptr_q       <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    p_q <= p_d;
    if (dig_we) begin
      digit_q[dig_wa] <= dig_wd;
    end
  end

  ris_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (dv_load),
    .step_i     (dv_step),
    .rem_init_i (dv_rem_init),
    .num_i      (dv_num),
    .divisor_i  (dv_divisor),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem),
    .more_o     (dv_more)
  );

  always_comb begin
    status_o.digits_ok    = digits_ok_q;
    status_o.idx_zero     = (idx_q == '0);
    status_o.div_more     = dv_more;
    status_o.quot_nonzero = (dv_quot != '0);
    status_o.carry        = ~at_top & digit_max;
    status_o.acc_more     = (DCNT_W'(ptr_q + DCNT_W'(1)) < n_q);
  end

  assign point_o = dv_quot;
  assign index_o = idx_q;

endmodule

@@ hdl/ris_sequencer.sv @@
// ris_sequencer: micro program counter, control store lookup and branch logic
// depends on ris_pkg (control word layout and program)
module ris_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 out_free_i,
  input  ris_pkg::dp_status_t  status_i,
  output ris_pkg::op_e         op_o,
  output logic                 idle_o
);
  import ris_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;
  logic             taken;

  always_comb begin
    uw = ucode(upc_q);
    case (uw.cond)
      COND_ALWAYS:       taken = 1'b1;
      COND_NO_START:     taken = ~start_i;
      COND_DIGITS_OK:    taken = status_i.digits_ok;
      COND_IDX_ZERO:     taken = status_i.idx_zero;
      COND_DIV_MORE:     taken = status_i.div_more;
      COND_QUOT_NONZERO: taken = status_i.quot_nonzero;
      COND_CARRY:        taken = status_i.carry;
      COND_ACC_MORE:     taken = status_i.acc_more;
      COND_OUT_FREE:     taken = out_free_i;
      default:           taken = 1'b1;
    endcase
    upc_d = taken ? uw.target : UPC_W'(upc_q + UPC_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign op_o   = uw.op;
  assign idle_o = (upc_q == UA_IDLE);

endmodule

@@ hdl/radical_inverse_sequence.sv @@
// radical_inverse_sequence: van der corput sequence generator, top level
// handshakes, output register and the sequencer / datapath pair
// depends on ris_pkg, ris_sequencer, ris_datapath
//
// input channel: each word carries advance_i. a word with advance_i high bumps the
// 32-bit index (wrapping to zero) and yields one output word with the new index and
// point = floor(mirror(index) * 2^32), the base-radix digits reflected about the point.
// a word with advance_i low is taken and dropped, no output.
// config channel: cfg_radix_i sets the base, always ready; 0 and 1 act as 2.
// write it only while no word is in flight.
// datapath: digits are kept in the current base and bumped with a ripple carry, one
// digit per cycle. then the mirror and base^digits are built digit by digit, and a
// bit-serial divide scales the fraction. in_ready_o is high only while the sequencer
// sits idle, one word at a time.
// after a radix write the digits are rebuilt by repeated division on the next
// advancing word only; on an index wrap the wrapping word itself restarts them from zero.
// reset: index 0, radix 2, output empty.
// a stalled receiver holds the finished word in the output register; the next input
// word is still taken and runs until its own result needs the register.
module radical_inverse_sequence (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         advance_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ris_pkg::FRAC_W-1:0]   point_o,
  output logic [ris_pkg::IDX_W-1:0]    index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ris_pkg::RADIX_W-1:0]  cfg_radix_i
);
  import ris_pkg::*;

  op_e               op;
  dp_status_t        status;
  logic              idle;
  logic              in_accept;
  logic              start;
  logic              out_free;
  logic              out_load;
  logic              cfg_we;
  logic [FRAC_W-1:0] dp_point;
  logic [IDX_W-1:0]  dp_index;

  logic              out_valid_q, out_valid_d;
  logic [FRAC_W-1:0] out_point_q;
  logic [IDX_W-1:0]  out_index_q;

  assign in_ready_o  = idle;
  assign in_accept   = in_valid_i & in_ready_o;
  assign start       = in_accept & advance_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_load    = (op == OP_FINISH) & out_free;

  ris_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .status_i   (status),
    .op_o       (op),
    .idle_o     (idle)
  );

  ris_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .start_i     (start),
    .cfg_we_i    (cfg_we),
    .cfg_radix_i (cfg_radix_i),
    .status_o    (status),
    .point_o     (dp_point),
    .index_o     (dp_index)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_point_q <= dp_point;
      out_index_q <= dp_index;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_o     = out_point_q;
  assign index_o     = out_index_q;

  // the index moves only on an accepted advance
  a_idx_only_on_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(dp_index) |-> $past(start))
    else $error("index changed without an accepted advance");

  // a fresh output word carries the index the datapath holds
  a_out_index_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_index_q == dp_index))
    else $error("output index does not match stored index");

  // a word without advance leaves the block ready for the next one
  a_drop_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !advance_i) |=> in_ready_o)
    else $error("ignored word left the sequencer busy");

endmodule

@@ dv/ris_checker.sv @@
// ris_checker: watches the input, output and radix channels of radical_inverse_sequence,
// predicts each output word (mirrored base-radix digits as a 32-bit fraction) and compares
// depends on ris_pkg
module ris_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        advance_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [ris_pkg::FRAC_W-1:0]  point_i,
  input  logic [ris_pkg::IDX_W-1:0]   index_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [ris_pkg::RADIX_W-1:0] cfg_radix_i,
  output int                          pending_o,
  output int                          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ris_pkg::*;

  typedef struct packed {
    logic [FRAC_W-1:0] point;
    logic [IDX_W-1:0]  index;
  } seq_word_t;

  seq_word_t          points_due[$];
  logic [IDX_W-1:0]   seq_index;
  logic [RADIX_W-1:0] radix;
  int                 fail_count;

  // floor(mirror(idx) * 2^FRAC_W), horner from the most significant digit keeps it exact
  function automatic logic [FRAC_W-1:0] mirror_point(input logic [IDX_W-1:0] idx,
                                                     input logic [RADIX_W-1:0] rdx);
    logic [63:0]        base;
    logic [63:0]        rest;
    logic [63:0]        frac;
    logic [RADIX_W-1:0] digit [MAX_DIGITS];
    int                 n;
    int                 i;
    base = (rdx < RADIX_MIN) ? 64'(RADIX_MIN) : 64'(rdx);
    rest = 64'(idx);
    frac = '0;
    n    = 0;
    while (rest != 0) begin
      digit[n] = RADIX_W'(rest % base);
      n++;
      rest = rest / base;
    end
    for (i = n - 1; i >= 0; i--) begin
      frac = ((64'(digit[i]) << FRAC_W) + frac) / base;
    end
    return frac[FRAC_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("ERROR: %0t %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seq_word_t want;
    if (!rst_ni) begin
      seq_index  = '0;
      radix      = RADIX_RESET;
      fail_count = 0;
      points_due.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        radix = cfg_radix_i;
      end
      // check the output before queuing a new word so an input taken in the same cycle is not matched against it
      if (out_valid_i && out_ready_i) begin
        if (points_due.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected: point %h index %h",
                                    point_i, index_i));
        end else begin
          want = points_due.pop_front();
          if (point_i !== want.point) begin
            report_mismatch($sformatf("index %h: point %h, expected %h",
                                      want.index, point_i, want.point));
          end
          if (index_i !== want.index) begin
            report_mismatch($sformatf("index %h, expected %h", index_i, want.index));
          end
        end
      end
      if (in_valid_i && in_ready_i && advance_i) begin
        seq_index = IDX_W'(seq_index + IDX_W'(1));
        points_due.push_back('{point: mirror_point(seq_index, radix), index: seq_index});
      end
      pending_o <= points_due.size();
      errors_o  <= fail_count;
    end
  end

endmodule

@@ dv/tb_top.sv @@
// tb_top: stimulus, idling and verdict for radical_inverse_sequence
// runs radix phases with random advance words under varied handshake pressure
// depends on ris_pkg, radical_inverse_sequence and ris_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ris_pkg::*;

  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          SETTLE_CYCLES   = 100;
  localparam int          PHASES          = 12;
  localparam int          WORDS_PER_PHASE = 71;
  // opening words at the reset radix, lsb first: mixes dropped and advancing words
  localparam logic [11:0] OPENING_ADV     = 12'b1110_1110_0110;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               advance_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [FRAC_W-1:0]  point_o;
  logic [IDX_W-1:0]   index_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [RADIX_W-1:0] cfg_radix_i = '0;

  int pending;
  int errors;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int idle_cycles = 0;

  radical_inverse_sequence i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .advance_i   (advance_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_o     (point_o),
    .index_o     (index_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_radix_i (cfg_radix_i)
  );

  ris_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .advance_i   (advance_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_i     (point_o),
    .index_i     (index_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_radix_i (cfg_radix_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic adv);
    in_valid_i <= 1'b1;
    advance_i  <= adv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pace_sender();
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      advance_i  <= 1'($urandom);
      @(posedge clk_i);
    end
  endtask

  // drain all expected words, then idle further with the input channel quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_radix_i <= RADIX_W'($urandom);
  endtask

  initial begin
    logic [RADIX_W-1:0] rdx;
    logic               adv;
    int                 sent;
    int                 p;
    int                 i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset base, no idling, dropped words between advancing ones
    for (i = 0; i < 12; i++) begin
      send_word(OPENING_ADV[i]);
    end

    // index wrap to zero needs 2^32 words and is out of reach here
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       rdx = 9'd0;
        1:       rdx = 9'd511;
        2:       rdx = 9'd1;
        3:       rdx = 9'd257;
        4:       rdx = 9'd256;
        5:       rdx = 9'd3;
        6:       rdx = 9'd2;
        7:       rdx = 9'd10;
        8:       rdx = RADIX_W'($urandom_range(257, 511));
        default: rdx = RADIX_W'($urandom_range(2, 256));
      endcase
      write_radix(rdx);
      case (p % 4)
        0: begin
          gap_pct   = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct   = 46;
          stall_pct <= 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct <= 46;
        end
        default: begin
          gap_pct   = 34;
          stall_pct <= 34;
        end
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        adv = ($urandom_range(9) != 0);
        pace_sender();
        send_word(adv);
        sent++;
      end
    end

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ radical_inverse_sequence.f @@
hdl/ris_pkg.sv
hdl/ris_divider.sv
hdl/ris_datapath.sv
hdl/ris_sequencer.sv
hdl/radical_inverse_sequence.sv
dv/ris_checker.sv
dv/tb_top.sv
